// ----- sv/isc_pkg.sv -----
// Shared types, constants and check-digit arithmetic for the identifier string classifier
`timescale 1ns / 1ps

package isc_pkg;

    // Result kind codes
    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_PLATE = 2'd1,
        KIND_CPF   = 2'd2,
        KIND_EMAIL = 2'd3
    } t_kind;

    // Character codes, lengths, digit positions and weights
    localparam logic [7:0] CHAR_AT    = 8'h40;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [3:0] LEN_SAT    = 4'd12;
    localparam logic [3:0] LEN_PLATE  = 4'd7;
    localparam logic [3:0] LEN_CPF    = 4'd11;
    localparam logic [3:0] PREFIX_LEN = 4'd3;
    localparam logic [3:0] POS_TENTH  = 4'd9;
    localparam logic [3:0] POS_ELEVEN = 4'd10;
    localparam logic [3:0] WEIGHT1    = 4'd10;
    localparam logic [3:0] WEIGHT2    = 4'd11;
    localparam logic [1:0] DOT_SAT    = 2'd3;

    // Reciprocal of 11 in 16 fractional bits, exact for 10-bit dividends
    localparam logic [12:0] RECIP11   = 13'd5958;
    localparam logic [3:0]  MOD11     = 4'd11;

    // Snapshot of a finished string, handed to the check-digit stage
    typedef struct packed {
        t_kind       kind;
        logic [8:0]  sum1;
        logic [9:0]  sum2;
        logic [3:0]  digit10;
        logic [3:0]  digit11;
    } t_fin;

    // Check digit: (10 * sum) mod 11, with 10 mapped to 0.
    // Since 10 = -1 mod 11 this is (11 - sum mod 11) mod 11.
    function automatic logic [3:0] check_digit(input logic [9:0] sum);
        logic [22:0] prod;
        logic [6:0]  quo;
        logic [9:0]  rem;
        logic [3:0]  m;
        prod = 23'(sum) * 23'(RECIP11);
        quo  = prod[22:16];
        rem  = sum - 10'(quo * 7'(MOD11));
        m    = rem[3:0];
        if (m == 4'd0 || m == 4'd1) begin
            check_digit = 4'd0;
        end else begin
            check_digit = MOD11 - m;
        end
    endfunction

endpackage

// ----- sv/isc_check.sv -----
// CPF check-digit comparison for a finished string
`timescale 1ns / 1ps

module isc_check (
    input  isc_pkg::t_fin i_fin,
    output logic          o_cpf_valid
);

    logic [3:0] w_d1;
    logic [3:0] w_d2;

    // Both check digits must match the stored tenth and eleventh digits
    always_comb begin
        w_d1        = isc_pkg::check_digit({1'b0, i_fin.sum1});
        w_d2        = isc_pkg::check_digit(i_fin.sum2);
        o_cpf_valid = (i_fin.kind == isc_pkg::KIND_CPF) &&
                      (w_d1 == i_fin.digit10) && (w_d2 == i_fin.digit11);
    end

endmodule

// ----- sv/identifier_string_classifier_top.sv -----
// Top level of the streaming identifier string classifier
`timescale 1ns / 1ps
//
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_stall    i_char_code[7:0], i_last_char
// result    out        o_valid / i_stall    o_kind[1:0], o_cpf_valid
//
// One character is taken every cycle while o_stall is low; the string state
// updates in the same edge. A result passes through the snapshot register,
// then the check-digit stage into the output register.
// Reset clears the string state and both valid flags.
// A stalled result holds; input stalls only when both result stages are full
// and the result is stalled.

module identifier_string_classifier_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_char_code,
    input  logic       i_last_char,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_kind,
    output logic       o_cpf_valid
);

    // String state
    logic [3:0] r_len,  n_len;
    logic       r_first3, n_first3;
    logic       r_tail, n_tail;
    logic       r_all,  n_all;
    logic       r_at,   n_at;
    logic [1:0] r_dot,  n_dot;
    logic [8:0] r_sum1, n_sum1;
    logic [9:0] r_sum2, n_sum2;
    logic [3:0] r_d10,  n_d10;
    logic [3:0] r_d11,  n_d11;

    // Snapshot and output stages
    logic                r_fin_valid;
    isc_pkg::t_fin       r_fin, n_fin;
    logic                r_out_valid;
    logic [1:0]          r_out_kind;
    logic                r_out_cpf;
    logic                w_cpf_valid;

    logic       w_en_out, w_en_fin, w_accept;
    logic       w_dig, w_letter;
    logic [3:0] w_val;
    logic [3:0] w_wt1, w_wt2;

    // Stage enables
    assign w_en_out = !r_out_valid || !i_stall;
    assign w_en_fin = !r_fin_valid || w_en_out;
    assign o_stall  = !w_en_fin;
    assign w_accept = i_valid && w_en_fin;

    // Character classes
    always_comb begin
        w_dig    = (i_char_code >= 8'h30) && (i_char_code <= 8'h39);
        w_letter = ((i_char_code >= 8'h41) && (i_char_code <= 8'h5A)) ||
                   ((i_char_code >= 8'h61) && (i_char_code <= 8'h7A));
        w_val    = w_dig ? 4'(i_char_code - isc_pkg::CHAR_ZERO) : 4'd0;
        w_wt1    = isc_pkg::WEIGHT1 - r_len;
        w_wt2    = isc_pkg::WEIGHT2 - r_len;
    end

    // Next string state after this character
    always_comb begin
        n_first3 = r_first3;
        n_tail   = r_tail;
        if (r_len < isc_pkg::PREFIX_LEN) begin
            n_first3 = r_first3 && w_letter;
        end else begin
            n_tail = r_tail && w_dig;
        end
        n_all = r_all && w_dig;
        n_at  = r_at || (i_char_code == isc_pkg::CHAR_AT);
        n_dot = r_dot;
        if (r_dot != 2'd0) begin
            if (r_dot < isc_pkg::DOT_SAT) begin
                n_dot = r_dot + 2'd1;
            end
        end else if (i_char_code == isc_pkg::CHAR_DOT) begin
            n_dot = 2'd1;
        end
        n_sum1 = r_sum1;
        if (r_len < isc_pkg::POS_TENTH) begin
            n_sum1 = r_sum1 + 9'(8'(w_val) * 8'(w_wt1));
        end
        n_sum2 = r_sum2;
        if (r_len < isc_pkg::POS_ELEVEN) begin
            n_sum2 = r_sum2 + 10'(8'(w_val) * 8'(w_wt2));
        end
        n_d10 = (r_len == isc_pkg::POS_TENTH)  ? w_val : r_d10;
        n_d11 = (r_len == isc_pkg::POS_ELEVEN) ? w_val : r_d11;
        n_len = (r_len < isc_pkg::LEN_SAT) ? r_len + 4'd1 : r_len;
    end

    // Kind of the finished string
    always_comb begin
        n_fin.kind = isc_pkg::KIND_NONE;
        if (n_len == isc_pkg::LEN_PLATE) begin
            if (n_first3 && n_tail) begin
                n_fin.kind = isc_pkg::KIND_PLATE;
            end
        end else if (n_len == isc_pkg::LEN_CPF) begin
            if (n_all) begin
                n_fin.kind = isc_pkg::KIND_CPF;
            end
        end else if (n_at && (n_dot == isc_pkg::DOT_SAT)) begin
            n_fin.kind = isc_pkg::KIND_EMAIL;
        end
        n_fin.sum1    = n_sum1;
        n_fin.sum2    = n_sum2;
        n_fin.digit10 = n_d10;
        n_fin.digit11 = n_d11;
    end

    // String state registers; the last character returns them to reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_accept && i_last_char)) begin
            r_len    <= 4'd0;
            r_first3 <= 1'b1;
            r_tail   <= 1'b1;
            r_all    <= 1'b1;
            r_at     <= 1'b0;
            r_dot    <= 2'd0;
            r_sum1   <= 9'd0;
            r_sum2   <= 10'd0;
            r_d10    <= 4'd0;
            r_d11    <= 4'd0;
        end else if (w_accept) begin
            r_len    <= n_len;
            r_first3 <= n_first3;
            r_tail   <= n_tail;
            r_all    <= n_all;
            r_at     <= n_at;
            r_dot    <= n_dot;
            r_sum1   <= n_sum1;
            r_sum2   <= n_sum2;
            r_d10    <= n_d10;
            r_d11    <= n_d11;
        end
    end

    // Snapshot stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (w_en_fin) begin
            r_fin_valid <= w_accept && i_last_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_last_char) begin
            r_fin <= n_fin;
        end
    end

    isc_check u_check (
        .i_fin       (r_fin),
        .o_cpf_valid (w_cpf_valid)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en_out) begin
            r_out_valid <= r_fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_out && r_fin_valid) begin
            r_out_kind <= r_fin.kind;
            r_out_cpf  <= w_cpf_valid;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_cpf_valid = r_out_cpf;

    // Checks
    a_cpf_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_cpf_valid |-> o_kind == isc_pkg::KIND_CPF)
        else $error("cpf_valid set on a non-CPF result");

    a_len_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= isc_pkg::LEN_SAT)
        else $error("length count beyond saturation");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_fin_valid && r_out_valid)
        else $error("input stalled with a free result stage");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_last_char |=> r_len == 4'd0 && r_fin_valid)
        else $error("string state not cleared after last character");

endmodule
